/* rtl/roi_stats_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ROI statistics package
// Shared types, register indexes and reset constants for the region-of-
// interest pixel statistics block.
// ----------------------------------------------------------------------------
package roi_stats_pkg;

  // Configuration port geometry.
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int ROI_W       = 11;
  localparam int DIM_W       = 16;
  localparam int POS_W       = 16;
  localparam int STAT_W      = 32;
  localparam int PIXEL_W     = 24;
  localparam int MASK_W      = 3;

  // Stream payload widths.
  localparam int S_TDATA_W = 32;
  localparam int M_TDATA_W = 192;
  localparam int M_TUSER_W = 2;

  // Reset values of the frame size registers.
  localparam logic [DIM_W-1:0]  FRAME_WIDTH_RST  = 16'd640;
  localparam logic [DIM_W-1:0]  FRAME_HEIGHT_RST = 16'd480;
  localparam logic [STAT_W-1:0] FRAME_TOTAL_RST  = 32'd307200;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ROI_LEFT     = 3'd0,
    REG_ROI_TOP      = 3'd1,
    REG_ROI_RIGHT    = 3'd2,
    REG_ROI_BOTTOM   = 3'd3,
    REG_FRAME_WIDTH  = 3'd4,
    REG_FRAME_HEIGHT = 3'd5
  } cfg_reg_t;

  // Settings seen by the statistics engine.
  typedef struct packed {
    logic [ROI_W-1:0]  roi_left;
    logic [ROI_W-1:0]  roi_top;
    logic [ROI_W-1:0]  roi_right;
    logic [ROI_W-1:0]  roi_bottom;
    logic [STAT_W-1:0] frame_total;
  } roi_cfg_t;

  // One result beat before packing onto the stream.
  typedef struct packed {
    logic [PIXEL_W-1:0] pixel_data;
    logic               start_of_frame;
    logic               end_of_line;
    logic [MASK_W-1:0]  byte_keep;
    logic [MASK_W-1:0]  byte_strobe;
    logic               frame_done;
    logic [STAT_W-1:0]  sum_red;
    logic [STAT_W-1:0]  sum_green;
    logic [STAT_W-1:0]  sum_blue;
    logic [STAT_W-1:0]  region_pixel_count;
    logic [STAT_W-1:0]  frames_completed;
  } roi_result_t;

  // A frame dimension of zero counts as one.
  function automatic logic [DIM_W-1:0] fix_dim(input logic [DIM_W-1:0] d);
    fix_dim = (d == '0) ? DIM_W'(1) : d;
  endfunction

endpackage
`default_nettype wire

/* rtl/roi_stats_regs.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ROI statistics configuration registers
// Holds the region bounds and the frame size, and keeps the pixel count of
// one frame up to date whenever a size register is written.
// ----------------------------------------------------------------------------
module roi_stats_regs (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_we,
  input  wire logic [roi_stats_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [roi_stats_pkg::CFG_DATA_W-1:0]  cfg_data,
  output roi_stats_pkg::roi_cfg_t                   cfg
);
  import roi_stats_pkg::*;

  logic [DIM_W-1:0]  frame_width;
  logic [DIM_W-1:0]  frame_height;
  logic [DIM_W-1:0]  mul_a;
  logic [DIM_W-1:0]  mul_b;
  logic [STAT_W-1:0] total_next;

  // The product uses the new value of whichever dimension is being written.
  always_comb begin
    mul_a = frame_width;
    mul_b = frame_height;
    if (cfg_we && (cfg_reg_t'(cfg_index) == REG_FRAME_WIDTH)) begin
      mul_a = cfg_data;
    end
    if (cfg_we && (cfg_reg_t'(cfg_index) == REG_FRAME_HEIGHT)) begin
      mul_b = cfg_data;
    end
    total_next = STAT_W'(fix_dim(mul_a)) * STAT_W'(fix_dim(mul_b));
  end

  // Register writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.roi_left    <= '0;
      cfg.roi_top     <= '0;
      cfg.roi_right   <= '0;
      cfg.roi_bottom  <= '0;
      cfg.frame_total <= FRAME_TOTAL_RST;
      frame_width     <= FRAME_WIDTH_RST;
      frame_height    <= FRAME_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ROI_LEFT:   cfg.roi_left   <= cfg_data[ROI_W-1:0];
        REG_ROI_TOP:    cfg.roi_top    <= cfg_data[ROI_W-1:0];
        REG_ROI_RIGHT:  cfg.roi_right  <= cfg_data[ROI_W-1:0];
        REG_ROI_BOTTOM: cfg.roi_bottom <= cfg_data[ROI_W-1:0];
        REG_FRAME_WIDTH: begin
          frame_width     <= cfg_data;
          cfg.frame_total <= total_next;
        end
        REG_FRAME_HEIGHT: begin
          frame_height    <= cfg_data;
          cfg.frame_total <= total_next;
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

/* rtl/roi_stats_engine.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ROI statistics engine
// Tracks pixel position and frame progress, accumulates the region sums and
// forms the result beat for each accepted pixel combinationally.
// ----------------------------------------------------------------------------
module roi_stats_engine (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire roi_stats_pkg::roi_cfg_t              cfg,
  input  wire logic                                 accept,
  input  wire logic [roi_stats_pkg::PIXEL_W-1:0]     pixel_data,
  input  wire logic                                 start_of_frame,
  input  wire logic                                 end_of_line,
  input  wire logic [roi_stats_pkg::MASK_W-1:0]      byte_keep,
  input  wire logic [roi_stats_pkg::MASK_W-1:0]      byte_strobe,
  output roi_stats_pkg::roi_result_t                result
);
  import roi_stats_pkg::*;

  logic [STAT_W-1:0] pixel_index;
  logic [POS_W-1:0]  column_pos;
  logic [POS_W-1:0]  row_pos;
  logic [STAT_W-1:0] red_acc;
  logic [STAT_W-1:0] green_acc;
  logic [STAT_W-1:0] blue_acc;
  logic [STAT_W-1:0] region_count;
  logic [STAT_W-1:0] frame_count;

  logic              in_region;
  logic [STAT_W-1:0] red_next;
  logic [STAT_W-1:0] green_next;
  logic [STAT_W-1:0] blue_next;
  logic [STAT_W-1:0] count_next;
  logic [STAT_W-1:0] index_next;
  logic [STAT_W-1:0] frame_next;
  logic              done;

  // Region test, accumulation and end-of-frame detection.
  always_comb begin
    in_region = (column_pos >= POS_W'(cfg.roi_left)) && (column_pos < POS_W'(cfg.roi_right)) &&
                (row_pos >= POS_W'(cfg.roi_top)) && (row_pos < POS_W'(cfg.roi_bottom));
    red_next   = red_acc   + STAT_W'(in_region ? pixel_data[7:0]   : 8'd0);
    green_next = green_acc + STAT_W'(in_region ? pixel_data[15:8]  : 8'd0);
    blue_next  = blue_acc  + STAT_W'(in_region ? pixel_data[23:16] : 8'd0);
    count_next = region_count + STAT_W'(in_region);
    index_next = pixel_index + STAT_W'(1);
    frame_next = frame_count + STAT_W'(1);
    done       = (index_next >= cfg.frame_total);
  end

  // Result beat: statistics fields read zero except on the closing pixel.
  always_comb begin
    result.pixel_data         = pixel_data;
    result.start_of_frame     = start_of_frame;
    result.end_of_line        = end_of_line;
    result.byte_keep          = byte_keep;
    result.byte_strobe        = byte_strobe;
    result.frame_done         = done;
    result.sum_red            = done ? red_next   : '0;
    result.sum_green          = done ? green_next : '0;
    result.sum_blue           = done ? blue_next  : '0;
    result.region_pixel_count = done ? count_next : '0;
    result.frames_completed   = done ? frame_next : '0;
  end

  // Frame state update on each accepted beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_index  <= '0;
      column_pos   <= '0;
      row_pos      <= '0;
      red_acc      <= '0;
      green_acc    <= '0;
      blue_acc     <= '0;
      region_count <= '0;
      frame_count  <= '0;
    end else if (accept) begin
      if (done) begin
        pixel_index  <= '0;
        column_pos   <= '0;
        row_pos      <= '0;
        red_acc      <= '0;
        green_acc    <= '0;
        blue_acc     <= '0;
        region_count <= '0;
        frame_count  <= frame_next;
      end else begin
        pixel_index  <= index_next;
        column_pos   <= end_of_line ? '0 : column_pos + POS_W'(1);
        row_pos      <= end_of_line ? row_pos + POS_W'(1) : row_pos;
        red_acc      <= red_next;
        green_acc    <= green_next;
        blue_acc     <= blue_next;
        region_count <= count_next;
      end
    end
  end

  // A closing pixel leaves the frame state cleared.
  a_frame_clears: assert property (@(posedge clk) disable iff (rst)
    accept && done |=> (pixel_index == '0) && (column_pos == '0) && (row_pos == '0) &&
                       (region_count == '0))
    else $error("frame state not cleared after frame end");

  // Any other accepted pixel advances the frame index by exactly one.
  a_index_step: assert property (@(posedge clk) disable iff (rst)
    accept && !done |=> pixel_index == $past(pixel_index) + STAT_W'(1))
    else $error("pixel index did not advance by one");

  // The region count never runs ahead of the pixels seen in the frame.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    region_count <= pixel_index)
    else $error("region count exceeds pixels seen");

endmodule
`default_nettype wire

/* rtl/roi_stats_outbuf.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ROI statistics output buffer
// Output register plus one skid entry, so the input side keeps taking beats
// while a finished result waits on the output side.
// ----------------------------------------------------------------------------
module roi_stats_outbuf (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire roi_stats_pkg::roi_result_t in_beat,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output roi_stats_pkg::roi_result_t      out_beat
);
  import roi_stats_pkg::*;

  logic        skid_valid;
  roi_result_t skid_beat;
  logic        take_in;

  assign in_ready = !skid_valid;
  assign take_in  = in_valid && in_ready;

  // Control: the output register refills from the skid entry first.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid  <= skid_valid || take_in;
      skid_valid <= 1'b0;
    end else if (take_in) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      out_beat <= skid_valid ? skid_beat : in_beat;
    end else if (take_in) begin
      skid_beat <= in_beat;
    end
  end

  // The skid entry is only ever used behind a full output register.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry holds data while output register is empty");

  // A beat taken while the output stalls lands in the skid entry.
  a_stall_to_skid: assert property (@(posedge clk) disable iff (rst)
    take_in && out_valid && !out_ready |=> skid_valid && out_valid)
    else $error("beat lost during output stall");

  // Reset empties both entries.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !skid_valid)
    else $error("buffer not empty after reset");

endmodule
`default_nettype wire

/* rtl/roi_pixel_statistics_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ROI pixel statistics core
// Passes an RGB888 pixel stream through and reports per-frame red, green and
// blue sums and a pixel count over a rectangular region of interest.
// ----------------------------------------------------------------------------
// Every input beat produces exactly one output beat, one per clock when both
// sides keep flowing: the position, region test and 32-bit accumulators are
// updated from the accepted beat, and the result sits in an output register
// backed by a one-entry skid buffer, so s_tready only drops once two beats
// are waiting, one in the output register and one in the skid entry.
// Columns restart on tlast; a frame ends on the pixel that brings the pixel
// count to at least frame_width x frame_height (zero counts as one), and that beat
// carries frame_done in tuser together with the sums, the count and the frame
// number (the first frame is 1); start-of-frame is passed through only.
// Configuration writes take effect on the next clock and are meant to happen
// while the stream is idle.
module roi_pixel_statistics_core (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // Configuration write port.
  input  wire logic                                 cfg_we,
  input  wire logic [roi_stats_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [roi_stats_pkg::CFG_DATA_W-1:0]  cfg_data,
  // Pixel input.
  input  wire logic                                 s_tvalid,
  output logic                                      s_tready,
  // s_tdata, low bit up: pixel_data[23:0], byte_keep[26:24], byte_strobe[29:27], zero pad
  input  wire logic [roi_stats_pkg::S_TDATA_W-1:0]   s_tdata,
  input  wire logic                                 s_tlast,  // end_of_line
  input  wire logic                                 s_tuser,  // start_of_frame
  // Pixel and statistics output.
  output logic                                      m_tvalid,
  input  wire logic                                 m_tready,
  // m_tdata, low bit up: pixel_data_out[23:0], byte_keep_out[26:24],
  // byte_strobe_out[29:27], sum_red[61:30], sum_green[93:62], sum_blue[125:94],
  // region_pixel_count[157:126], frames_completed[189:158], zero pad
  output logic [roi_stats_pkg::M_TDATA_W-1:0]        m_tdata,
  output logic                                      m_tlast,  // end_of_line_out
  // m_tuser, low bit up: start_of_frame_out, frame_done
  output logic [roi_stats_pkg::M_TUSER_W-1:0]        m_tuser
);
  import roi_stats_pkg::*;

  roi_cfg_t    cfg;
  roi_result_t result;
  roi_result_t out_beat;
  logic        accept;

  assign accept = s_tvalid && s_tready;

  // Configuration registers.
  roi_stats_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Position tracking and accumulation.
  roi_stats_engine u_engine (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .accept         (accept),
    .pixel_data     (s_tdata[23:0]),
    .start_of_frame (s_tuser),
    .end_of_line    (s_tlast),
    .byte_keep      (s_tdata[26:24]),
    .byte_strobe    (s_tdata[29:27]),
    .result         (result)
  );

  // Output register and skid entry.
  roi_stats_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_beat   (result),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_beat  (out_beat)
  );

  // Pack the result beat onto the output stream.
  assign m_tdata = {2'b00,
                    out_beat.frames_completed,
                    out_beat.region_pixel_count,
                    out_beat.sum_blue,
                    out_beat.sum_green,
                    out_beat.sum_red,
                    out_beat.byte_strobe,
                    out_beat.byte_keep,
                    out_beat.pixel_data};
  assign m_tlast = out_beat.end_of_line;
  assign m_tuser = {out_beat.frame_done, out_beat.start_of_frame};

endmodule
`default_nettype wire

/* verif/roi_pixel_statistics_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ROI pixel statistics core testbench
// Streams pixel beats into the core and compares every output beat, field by
// field, with a cycle-free model of the region sums, the pixel count and the
// frame counter. The input side sends in random bursts and the output side
// stalls on its own pattern. Directed tests cover channel extremes, zero and
// oversized frames, region edges, settings changed mid-frame, spare register
// indexes and a long output stall. Random frames follow.
// ----------------------------------------------------------------------------
module roi_pixel_statistics_core_tb;
  import roi_stats_pkg::*;

  localparam int HALF_PERIOD  = 6;
  localparam int RESET_CYCLES = 10;
  localparam int STALL_LIMIT  = 4000;
  localparam int HOLD_CYCLES  = 300;
  localparam int MAX_PRINTED  = 40;
  localparam int RANDOM_ITEMS = 1050;

  // Indexes past the end of the register map; writes to them are dropped.
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LOW  = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HIGH = 3'd7;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;
  typedef enum logic [1:0] {FRAME_CLEAN, FRAME_NOISE, FRAME_BROKEN} frame_shape_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   s_tvalid;
  logic                   s_tready;
  // s_tdata, low bit up: pixel_data, byte_keep, byte_strobe, zero pad
  logic [S_TDATA_W-1:0]   s_tdata;
  logic                   s_tlast;
  logic                   s_tuser;
  logic                   m_tvalid;
  logic                   m_tready;
  // m_tdata, low bit up: pixel_data_out, byte_keep_out, byte_strobe_out, sum_red,
  // sum_green, sum_blue, region_pixel_count, frames_completed, zero pad
  logic [M_TDATA_W-1:0]   m_tdata;
  logic                   m_tlast;
  // m_tuser, low bit up: start_of_frame_out, frame_done
  logic [M_TUSER_W-1:0]   m_tuser;

  roi_pixel_statistics_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

  // Model copy of the registers and of the frame state.
  logic [ROI_W-1:0]  cfg_left, cfg_top, cfg_right, cfg_bottom;
  logic [DIM_W-1:0]  cfg_width, cfg_height;
  logic [STAT_W-1:0] seen_pixels, acc_red, acc_green, acc_blue, acc_count, frame_no;
  logic [POS_W-1:0]  pos_col, pos_row;

  roi_result_t predicted_beats[$];

  int unsigned errors = 0;
  int unsigned items_sent = 0;
  int unsigned beats_checked = 0;
  int unsigned idle_cycles = 0;
  int unsigned burst_left = 8;
  bit          steady_sender = 1'b0;
  bit          last_frame_done = 1'b0;
  bit          hold_request = 1'b0;
  int unsigned hold_left = 0;
  int unsigned mode_left = 0;
  int unsigned rx_phase = 0;
  rx_mode_t    rx_mode = RX_OPEN;

  initial clk = 1'b0;
  always #(HALF_PERIOD) clk = ~clk;

  // Expected output beat for one accepted pixel; advances the model state.
  function automatic roi_result_t predict_beat(input logic [PIXEL_W-1:0] pix,
                                               input logic sof, input logic eol,
                                               input logic [MASK_W-1:0] keep,
                                               input logic [MASK_W-1:0] strb);
    roi_result_t beat;
    logic [STAT_W-1:0] w_eff, h_eff, total;
    logic hit;
    w_eff = (cfg_width == '0) ? 32'd1 : {16'd0, cfg_width};
    h_eff = (cfg_height == '0) ? 32'd1 : {16'd0, cfg_height};
    total = w_eff * h_eff;
    hit = (pos_col >= cfg_left) && (pos_col < cfg_right) &&
          (pos_row >= cfg_top) && (pos_row < cfg_bottom);
    if (hit) begin
      acc_red   += pix[7:0];
      acc_green += pix[15:8];
      acc_blue  += pix[23:16];
      acc_count += 1;
    end
    if (eol) begin
      pos_col = '0;
      pos_row += 1;
    end else begin
      pos_col += 1;
    end
    seen_pixels += 1;
    beat = '0;
    beat.pixel_data     = pix;
    beat.start_of_frame = sof;
    beat.end_of_line    = eol;
    beat.byte_keep      = keep;
    beat.byte_strobe    = strb;
    // The pixel that completes the frame carries the totals and clears them.
    if (seen_pixels >= total) begin
      frame_no += 1;
      beat.frame_done         = 1'b1;
      beat.sum_red            = acc_red;
      beat.sum_green          = acc_green;
      beat.sum_blue           = acc_blue;
      beat.region_pixel_count = acc_count;
      beat.frames_completed   = frame_no;
      seen_pixels = '0;
      pos_col     = '0;
      pos_row     = '0;
      acc_red     = '0;
      acc_green   = '0;
      acc_blue    = '0;
      acc_count   = '0;
    end
    return beat;
  endfunction

  function automatic logic [PIXEL_W-1:0] rand_pixel();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return PIXEL_W'($urandom());
    endcase
  endfunction

  task automatic report_error(input string msg);
    errors++;
    if (errors <= MAX_PRINTED) $display("mismatch: %s", msg);
  endtask

  task automatic check_field(input string name, input logic [STAT_W-1:0] got,
                             input logic [STAT_W-1:0] want);
    if (got !== want)
      report_error($sformatf("beat %0d %s got %h want %h", beats_checked, name, got, want));
  endtask

  // Register write; the model takes the value once the write has been clocked in.
  task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_ROI_LEFT:     cfg_left   = data[ROI_W-1:0];
      REG_ROI_TOP:      cfg_top    = data[ROI_W-1:0];
      REG_ROI_RIGHT:    cfg_right  = data[ROI_W-1:0];
      REG_ROI_BOTTOM:   cfg_bottom = data[ROI_W-1:0];
      REG_FRAME_WIDTH:  cfg_width  = data;
      REG_FRAME_HEIGHT: cfg_height = data;
      default: ;
    endcase
  endtask

  task automatic set_region(input logic [ROI_W-1:0] left, input logic [ROI_W-1:0] top,
                            input logic [ROI_W-1:0] right, input logic [ROI_W-1:0] bottom);
    cfg_write(REG_ROI_LEFT,   {5'($urandom()), left});
    cfg_write(REG_ROI_TOP,    {5'($urandom()), top});
    cfg_write(REG_ROI_RIGHT,  {5'($urandom()), right});
    cfg_write(REG_ROI_BOTTOM, {5'($urandom()), bottom});
  endtask

  // Offer one pixel beat and hold it until accepted, then maybe idle a while.
  task automatic send_pixel(input logic [PIXEL_W-1:0] pix, input logic sof,
                            input logic eol, input logic [MASK_W-1:0] keep,
                            input logic [MASK_W-1:0] strb);
    roi_result_t beat;
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, strb, keep, pix};
    s_tlast  <= eol;
    s_tuser  <= sof;
    do @(posedge clk); while (!s_tready);
    beat = predict_beat(pix, sof, eol, keep, strb);
    predicted_beats.push_back(beat);
    last_frame_done = beat.frame_done;
    items_sent++;
    if (!steady_sender) begin
      if (burst_left <= 1) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        burst_left = $urandom_range(1, 40);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic send_random(input logic sof, input logic eol);
    send_pixel(rand_pixel(), sof, eol, MASK_W'($urandom()), MASK_W'($urandom()));
  endtask

  // Stop offering and wait until every predicted beat has come out.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (predicted_beats.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_frame_size(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
    drain_results();
    cfg_write(REG_FRAME_WIDTH, w);
    cfg_write(REG_FRAME_HEIGHT, h);
  endtask

  task automatic finish_frame();
    do send_random(1'b0, 1'(($urandom_range(0, 1)))); while (!last_frame_done);
  endtask

  // Reset settings: empty region and a 640x480 frame, then a shrink ends it.
  task automatic test_reset_settings();
    send_pixel(24'h123456, 1'b1, 1'b0, 3'd7, 3'd7);
    send_pixel(24'hFFFFFF, 1'b0, 1'b0, 3'd0, 3'd0);
    send_pixel(24'h000000, 1'b0, 1'b1, 3'd5, 3'd2);
    set_frame_size(16'd1, 16'd2);
    send_pixel(24'hABCDEF, 1'b0, 1'b0, 3'd3, 3'd4);
  endtask

  // Full region written with the upper data bits set, extreme channel values.
  task automatic test_channel_extremes();
    drain_results();
    cfg_write(REG_ROI_LEFT, 16'hF800);
    cfg_write(REG_ROI_TOP, 16'hF800);
    cfg_write(REG_ROI_RIGHT, 16'hFFFF);
    cfg_write(REG_ROI_BOTTOM, 16'hFFFF);
    cfg_write(REG_FRAME_WIDTH, 16'd3);
    cfg_write(REG_FRAME_HEIGHT, 16'd2);
    send_pixel(24'h000000, 1'b1, 1'b0, 3'd0, 3'd7);
    send_pixel(24'hFFFFFF, 1'b0, 1'b0, 3'd7, 3'd0);
    send_pixel(24'h0000FF, 1'b0, 1'b1, 3'd1, 3'd6);
    send_pixel(24'h00FF00, 1'b0, 1'b0, 3'd2, 3'd5);
    send_pixel(24'hFF0000, 1'b0, 1'b0, 3'd4, 3'd3);
    send_pixel(24'hFFFFFF, 1'b0, 1'b1, 3'd7, 3'd7);
  endtask

  // A zero width or height counts as one, so every pixel ends a frame.
  task automatic test_zero_size();
    set_frame_size(16'd0, 16'd0);
    send_random(1'b1, 1'b0);
    send_random(1'b0, 1'b1);
  endtask

  // Single-pixel region in the middle of a 3x3 frame, then an inverted region.
  task automatic test_region_edges();
    int unsigned i;
    drain_results();
    set_region(11'd1, 11'd1, 11'd2, 11'd2);
    cfg_write(REG_FRAME_WIDTH, 16'd3);
    cfg_write(REG_FRAME_HEIGHT, 16'd3);
    for (i = 0; i < 9; i++) send_random(1'(i == 0), 1'(i % 3 == 2));
    drain_results();
    set_region(11'd2, 11'd0, 11'd1, 11'd2047);
    cfg_write(REG_FRAME_WIDTH, 16'd2);
    cfg_write(REG_FRAME_HEIGHT, 16'd1);
    send_random(1'b1, 1'b0);
    send_random(1'b0, 1'b1);
  endtask

  // Region and size changed between pixels of one oversized frame.
  task automatic test_midframe_changes();
    drain_results();
    set_region(11'd0, 11'd0, 11'd0, 11'd0);
    cfg_write(REG_FRAME_WIDTH, 16'hFFFF);
    cfg_write(REG_FRAME_HEIGHT, 16'hFFFF);
    send_pixel(24'hFFFFFF, 1'b1, 1'b0, 3'd7, 3'd7);
    send_pixel(24'hFFFFFF, 1'b0, 1'b0, 3'd7, 3'd7);
    drain_results();
    cfg_write(REG_ROI_RIGHT, 16'd2047);
    cfg_write(REG_ROI_BOTTOM, 16'd2047);
    send_pixel(24'h7F80FE, 1'b0, 1'b0, 3'd2, 3'd5);
    set_frame_size(16'd1, 16'd2);
    finish_frame();
  endtask

  // Writes past the register map must leave the 2x1 frame size alone.
  task automatic test_spare_indexes();
    set_frame_size(16'd2, 16'd1);
    cfg_write(REG_SPARE_LOW, 16'hFFFF);
    cfg_write(REG_SPARE_HIGH, 16'h0000);
    send_random(1'b1, 1'b0);
    send_random(1'b0, 1'b1);
  endtask

  // Output held off for a long stretch while the input keeps offering beats.
  task automatic test_output_stall();
    int unsigned i;
    drain_results();
    set_region(11'd0, 11'd0, 11'd2047, 11'd2047);
    cfg_write(REG_FRAME_WIDTH, 16'd4);
    cfg_write(REG_FRAME_HEIGHT, 16'd4);
    steady_sender = 1'b1;
    hold_request  = 1'b1;
    for (i = 0; i < 48; i++) send_random(1'(i % 16 == 0), 1'(i % 4 == 3));
    steady_sender = 1'b0;
    drain_results();
  endtask

  // Random settings, mostly well-formed frames with random pixels.
  task automatic test_random_frames();
    int unsigned first, ew, eh, n, i, f, nframes, left, right, top, bottom, swap_at;
    logic [DIM_W-1:0] w, h;
    frame_shape_t shape;
    logic sof, eol;
    first = items_sent;
    while (items_sent - first < RANDOM_ITEMS) begin
      drain_results();
      // Now and then start an oversized frame and shrink it part way.
      if ($urandom_range(0, 11) == 0) begin
        cfg_write(REG_FRAME_WIDTH, 16'hFFFF);
        cfg_write(REG_FRAME_HEIGHT, 16'($urandom_range(1, 65535)));
        repeat ($urandom_range(1, 5)) send_random(1'b0, 1'($urandom_range(0, 1)));
        set_frame_size(16'($urandom_range(1, 3)), 16'($urandom_range(1, 2)));
        finish_frame();
        drain_results();
      end
      w = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(7, 40)) : 16'($urandom_range(1, 6));
      h = 16'($urandom_range(1, 5));
      if ($urandom_range(0, 15) == 0) w = '0;
      if ($urandom_range(0, 15) == 0) h = '0;
      ew = (w == '0) ? 1 : w;
      eh = (h == '0) ? 1 : h;
      case ($urandom_range(0, 7))
        0: begin
          left = 0; top = 0; right = 2047; bottom = 2047;
        end
        1: begin
          left = $urandom_range(1, 2047); right = $urandom_range(0, left - 1);
          top = $urandom_range(0, 2047); bottom = $urandom_range(0, 2047);
        end
        2: begin
          left = $urandom_range(0, 2047); right = $urandom_range(0, 2047);
          top = $urandom_range(0, 2047); bottom = $urandom_range(0, 2047);
        end
        default: begin
          left = $urandom_range(0, ew); right = $urandom_range(0, ew + 1);
          top = $urandom_range(0, eh); bottom = $urandom_range(0, eh + 1);
        end
      endcase
      set_region(11'(left), 11'(top), 11'(right), 11'(bottom));
      cfg_write(REG_FRAME_WIDTH, w);
      cfg_write(REG_FRAME_HEIGHT, h);
      nframes = $urandom_range(1, 3);
      for (f = 0; f < nframes; f++) begin
        case ($urandom_range(0, 7))
          0:       shape = FRAME_NOISE;
          1:       shape = FRAME_BROKEN;
          default: shape = FRAME_CLEAN;
        endcase
        n = ew * eh;
        swap_at = ($urandom_range(0, 7) == 0) ? n / 2 : n;
        for (i = 0; i < n; i++) begin
          // Region bounds moved part way through a frame.
          if (i == swap_at && i != 0) begin
            drain_results();
            cfg_write(REG_ROI_LEFT, 16'($urandom_range(0, ew)));
            cfg_write(REG_ROI_RIGHT, 16'($urandom_range(0, ew + 1)));
          end
          case (shape)
            FRAME_NOISE: begin
              sof = 1'($urandom_range(0, 1));
              eol = 1'($urandom_range(0, 3) == 0);
            end
            FRAME_BROKEN: begin
              sof = 1'(i == 0);
              eol = 1'(i % (ew + 1) == ew);
            end
            default: begin
              sof = 1'(i == 0) ^ 1'($urandom_range(0, 15) == 0);
              eol = 1'(i % ew == ew - 1);
            end
          endcase
          send_random(sof, eol);
        end
      end
    end
  endtask

  // Compare each accepted output beat with the oldest prediction.
  always @(posedge clk) begin : result_check
    roi_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (predicted_beats.size() == 0) begin
        report_error($sformatf("beat %0d arrived with no pixel pending", beats_checked));
      end else begin
        want = predicted_beats.pop_front();
        check_field("pixel_data", m_tdata[23:0], want.pixel_data);
        check_field("byte_keep", m_tdata[26:24], want.byte_keep);
        check_field("byte_strobe", m_tdata[29:27], want.byte_strobe);
        check_field("sum_red", m_tdata[61:30], want.sum_red);
        check_field("sum_green", m_tdata[93:62], want.sum_green);
        check_field("sum_blue", m_tdata[125:94], want.sum_blue);
        check_field("region_pixel_count", m_tdata[157:126], want.region_pixel_count);
        check_field("frames_completed", m_tdata[189:158], want.frames_completed);
        check_field("tdata_pad", m_tdata[191:190], '0);
        check_field("end_of_line", m_tlast, want.end_of_line);
        check_field("start_of_frame", m_tuser[0], want.start_of_frame);
        check_field("frame_done", m_tuser[1], want.frame_done);
      end
      beats_checked++;
    end
  end

  // Output ready: a long hold when asked, otherwise a changing stall pattern.
  always @(posedge clk) begin
    rx_phase++;
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      case (rx_mode)
        RX_OPEN:   m_tready <= 1'b1;
        RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
        RX_SPARSE: m_tready <= 1'($urandom_range(0, 3) == 0);
        default:   m_tready <= 1'(rx_phase % 4 != 3);
      endcase
    end
  end

  // Watchdog on cycles with no beat accepted on either side.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == STALL_LIMIT) begin
      $display("watchdog: no beat accepted for %0d cycles", STALL_LIMIT);
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tlast   <= 1'b0;
    s_tuser   <= 1'b0;
    m_tready  <= 1'b0;
    cfg_left    = '0;
    cfg_top     = '0;
    cfg_right   = '0;
    cfg_bottom  = '0;
    cfg_width   = FRAME_WIDTH_RST;
    cfg_height  = FRAME_HEIGHT_RST;
    seen_pixels = '0;
    pos_col     = '0;
    pos_row     = '0;
    acc_red     = '0;
    acc_green   = '0;
    acc_blue    = '0;
    acc_count   = '0;
    frame_no    = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_settings();
    test_channel_extremes();
    test_zero_size();
    test_region_edges();
    test_midframe_changes();
    test_spare_indexes();
    test_output_stall();
    test_random_frames();

    drain_results();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
